@@ hdl/shc_pkg.sv @@
// ----------------------------------------------------------------------------
// Shepherd cache replacement package
// Types, request codes and constants shared by the replacement engine.
// ----------------------------------------------------------------------------
package shc_pkg;

    localparam int NUM_COLS = 4;
    localparam int COL_BITS = 5;
    localparam int FILL_CAP = 24;
    localparam logic [COL_BITS-1:0] COL_MAX = 5'd31;

    typedef enum logic [1:0] {
        REQ_HIT    = 2'd0,
        REQ_FILL   = 2'd1,
        REQ_VICTIM = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_UPD_RD,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]                   cls;
        logic [NUM_COLS-1:0]          flags;
        logic [NUM_COLS*COL_BITS-1:0] counts;
    } t_way_ent;

    typedef struct packed {
        logic [1:0]                   head;
        logic [NUM_COLS*COL_BITS-1:0] colcnt;
        logic [4:0]                   fill;
    } t_set_ent;

endpackage

@@ hdl/shc_req_if.sv @@
// ----------------------------------------------------------------------------
// Shepherd cache request channel
// Valid/ready channel carrying one replacement request.
// ----------------------------------------------------------------------------
interface shc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] set_index;
    logic [3:0] way_index;

    modport source (output valid, output req_type, output set_index, output way_index,
                    input ready);
    modport sink   (input valid, input req_type, input set_index, input way_index,
                    output ready);
endinterface

@@ hdl/shc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Shepherd cache victim channel
// Valid/ready channel carrying one victim selection.
// ----------------------------------------------------------------------------
interface shc_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_way;
    logic       victim_from_main;

    modport source (output valid, output victim_way, output victim_from_main,
                    input ready);
    modport sink   (input valid, input victim_way, input victim_from_main,
                    output ready);
endinterface

@@ hdl/shepherd_cache_replacement.sv @@
// ----------------------------------------------------------------------------
// Shepherd cache replacement engine
// Per-way and per-set replacement state in two synchronous memories,
// updated by read-modify-write on hit, fill and victim query.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  i_req    | in  | req_type, set_index, way_index
//  o_rsp    | out | victim_way, victim_from_main (victim query only)
//
//  Hit and fill read the memories, then write back; a hit writes only once the set is warm.
//  Victim query scans the set's ways in order, one read port on the way memory, until an
//  eligible flagged way or the last way; if any way was eligible, every way is then updated.
//  After reset a clearing pass over all SETS*WAYS entries runs before requests are taken.
//  A pending victim result stalls only the next victim's completion.
module shepherd_cache_replacement #(
    parameter int SETS      = 64,
    parameter int WAYS      = 16,
    parameter int MAIN_WAYS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    shc_req_if.sink   i_req,
    shc_rsp_if.source o_rsp
);

    localparam int NWAY = SETS * WAYS;
    localparam int WAW  = (NWAY > 1) ? $clog2(NWAY) : 1;
    localparam int SAW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW   = $clog2(WAYS);
    localparam int CAP  = (MAIN_WAYS > shc_pkg::FILL_CAP) ? MAIN_WAYS : shc_pkg::FILL_CAP;
    localparam int CB   = shc_pkg::COL_BITS;

    shc_pkg::t_way_ent way_mem [0:NWAY-1];
    shc_pkg::t_set_ent set_mem [0:SETS-1];

    shc_pkg::t_state r_state, n_state;
    logic [WAW-1:0]  r_clr, n_clr;
    logic [1:0]      r_type, n_type;
    logic [SAW-1:0]  r_set, n_set;
    logic [WAW-1:0]  r_base, n_base;
    logic [WAW-1:0]  r_addr, n_addr;
    logic [WW-1:0]   r_w, n_w;
    logic            r_any, n_any;
    logic [WW-1:0]   r_best, n_best;
    logic [CB-1:0]   r_bcnt, n_bcnt;
    logic            r_bmain, n_bmain;
    logic            r_ov, n_ov;
    logic [3:0]      r_vw, n_vw;
    logic            r_vm, n_vm;

    shc_pkg::t_way_ent r_wrd, w_wd;
    shc_pkg::t_set_ent r_srd, s_wd;
    logic              w_re, w_we, s_re, s_we;
    logic [WAW-1:0]    w_ra, w_wa;
    logic [SAW-1:0]    s_ra, s_wa;

    logic            acc, req_ok, warm, elig, flag, stop, last;
    logic [1:0]      h;
    logic [2:0]      hc;
    logic [CB-1:0]   cnt, cm;

    assign i_req.ready            = (r_state == shc_pkg::S_IDLE);
    assign acc                    = i_req.valid && i_req.ready;
    assign o_rsp.valid            = r_ov;
    assign o_rsp.victim_way       = r_vw;
    assign o_rsp.victim_from_main = r_vm;

    assign h    = r_srd.head;
    assign hc   = {1'b0, h} + 3'd1;
    assign warm = 32'(r_srd.fill) >= MAIN_WAYS;
    assign cnt  = r_wrd.counts[32'(h)*CB +: CB];
    assign elig = (r_wrd.cls == 3'd0) || (r_wrd.cls == hc);
    assign flag = r_wrd.flags[h];
    assign last = (r_w == WW'(WAYS - 1));
    assign stop = (elig && flag) || last;

    always_comb begin
        req_ok = 1'b0;
        if (32'(i_req.set_index) < SETS) begin
            case (i_req.req_type)
                shc_pkg::REQ_HIT, shc_pkg::REQ_FILL: req_ok = 32'(i_req.way_index) < WAYS;
                shc_pkg::REQ_VICTIM: req_ok = 1'b1;
                default: req_ok = 1'b0;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shc_pkg::S_CLEAR: if (r_clr == WAW'(NWAY - 1)) n_state = shc_pkg::S_IDLE;
            shc_pkg::S_IDLE: begin
                if (acc && req_ok) begin
                    n_state = (i_req.req_type == shc_pkg::REQ_VICTIM) ? shc_pkg::S_SCAN
                                                                      : shc_pkg::S_RMW;
                end
            end
            shc_pkg::S_RMW: n_state = shc_pkg::S_IDLE;
            shc_pkg::S_SCAN: begin
                if (stop) n_state = (r_any || elig) ? shc_pkg::S_UPD_RD : shc_pkg::S_DONE;
            end
            shc_pkg::S_UPD_RD: n_state = shc_pkg::S_UPD;
            shc_pkg::S_UPD: if (last) n_state = shc_pkg::S_DONE;
            shc_pkg::S_DONE: if (!r_ov || o_rsp.ready) n_state = shc_pkg::S_IDLE;
            default: n_state = shc_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr   = r_clr;
        n_type  = r_type;
        n_set   = r_set;
        n_base  = r_base;
        n_addr  = r_addr;
        n_w     = r_w;
        n_any   = r_any;
        n_best  = r_best;
        n_bcnt  = r_bcnt;
        n_bmain = r_bmain;
        n_ov    = r_ov && !o_rsp.ready;
        n_vw    = r_vw;
        n_vm    = r_vm;
        w_re = 1'b0; w_we = 1'b0; s_re = 1'b0; s_we = 1'b0;
        w_ra = r_addr; w_wa = r_addr; s_ra = r_set; s_wa = r_set;
        w_wd = r_wrd;
        s_wd = r_srd;
        cm   = '0;
        case (r_state)
            shc_pkg::S_CLEAR: begin
                n_clr = r_clr + WAW'(1);
                w_we = 1'b1;
                w_wa = r_clr;
                w_wd = '{cls: 3'd0, flags: '1, counts: '0};
                s_we = 32'(r_clr) < SETS;
                s_wa = r_clr[SAW-1:0];
                s_wd = '0;
            end
            shc_pkg::S_IDLE: begin
                n_type = i_req.req_type;
                n_set  = SAW'(i_req.set_index);
                n_base = WAW'(i_req.set_index) * WAW'(WAYS);
                n_addr = WAW'(i_req.set_index) * WAW'(WAYS) + WAW'(i_req.way_index);
                n_w    = '0;
                n_any  = 1'b0;
                if (acc && req_ok) begin
                    s_re = 1'b1;
                    s_ra = SAW'(i_req.set_index);
                    w_re = 1'b1;
                    w_ra = (i_req.req_type == shc_pkg::REQ_VICTIM) ? n_base : n_addr;
                end
            end
            shc_pkg::S_RMW: begin
                if (r_type == shc_pkg::REQ_HIT) begin
                    if (warm) begin
                        w_we = 1'b1;
                        s_we = 1'b1;
                        for (int c = 0; c < shc_pkg::NUM_COLS; c++) begin
                            if (r_wrd.flags[c]) begin
                                cm = r_srd.colcnt[c*CB +: CB];
                                w_wd.flags[c] = 1'b0;
                                w_wd.counts[c*CB +: CB] = cm;
                                if (cm != shc_pkg::COL_MAX) cm = cm + CB'(1);
                                s_wd.colcnt[c*CB +: CB] = cm;
                            end
                        end
                    end
                end else begin
                    w_we = 1'b1;
                    s_we = 1'b1;
                    if (!warm) begin
                        w_wd.cls = 3'd0;
                    end else begin
                        w_wd.cls = hc;
                        s_wd.colcnt[32'(h)*CB +: CB] = '0;
                        s_wd.head = h + 2'd1;
                    end
                    w_wd.flags = '1;
                    if (32'(r_srd.fill) < CAP) s_wd.fill = r_srd.fill + 5'd1;
                end
            end
            shc_pkg::S_SCAN: begin
                if (elig) begin
                    n_any = 1'b1;
                    if (!r_any || flag || cnt > r_bcnt) begin
                        n_best  = r_w;
                        n_bcnt  = cnt;
                        n_bmain = (r_wrd.cls == 3'd0);
                    end
                end
                if (!stop) begin
                    n_w  = r_w + WW'(1);
                    w_re = 1'b1;
                    w_ra = r_base + WAW'(r_w) + WAW'(1);
                end
                if (stop && !(r_any || elig)) begin
                    n_best  = '0;
                    n_bmain = 1'b0;
                end
            end
            shc_pkg::S_UPD_RD: begin
                n_w  = '0;
                w_re = 1'b1;
                w_ra = r_base;
            end
            shc_pkg::S_UPD: begin
                w_we = 1'b1;
                w_wa = r_base + WAW'(r_w);
                if (elig) w_wd.flags[h] = 1'b1;
                if (r_bmain && r_wrd.cls == hc) w_wd.cls = 3'd0;
                if (!last) begin
                    n_w  = r_w + WW'(1);
                    w_re = 1'b1;
                    w_ra = r_base + WAW'(r_w) + WAW'(1);
                end
            end
            shc_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov = 1'b1;
                    n_vw = 4'(r_best);
                    n_vm = r_bmain;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) way_mem[w_wa] <= w_wd;
        if (w_re) r_wrd <= way_mem[w_ra];
        if (s_we) set_mem[s_wa] <= s_wd;
        if (s_re) r_srd <= set_mem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shc_pkg::S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_set   <= n_set;
        r_base  <= n_base;
        r_addr  <= n_addr;
        r_w     <= n_w;
        r_any   <= n_any;
        r_best  <= n_best;
        r_bcnt  <= n_bcnt;
        r_bmain <= n_bmain;
        r_vw    <= n_vw;
        r_vm    <= n_vm;
    end

endmodule

@@ sim/shepherd_cache_replacement_tb.sv @@
// ----------------------------------------------------------------------------
// Shepherd cache replacement testbench
// Drives hit, fill and victim requests into the replacement engine, predicts
// each victim from a local copy of the per-way and per-set state, and checks
// every victim transaction against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shepherd_cache_replacement_tb;

    localparam int SETS      = 64;
    localparam int WAYS      = 16;
    localparam int MAIN_WAYS = 12;
    localparam int LIMIT     = 1500000;
    localparam int CAP       = (MAIN_WAYS > shc_pkg::FILL_CAP) ? MAIN_WAYS : shc_pkg::FILL_CAP;

    typedef struct packed {
        logic [3:0] way;
        logic       from_main;
    } t_victim;

    logic i_clk;
    logic i_rst_n;

    shc_req_if req_ch ();
    shc_rsp_if rsp_ch ();

    shepherd_cache_replacement #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .MAIN_WAYS(MAIN_WAYS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    logic [2:0]  cls_m    [SETS*WAYS];
    logic [3:0]  unseen_m [SETS*WAYS];
    logic [19:0] order_m  [SETS*WAYS];
    logic [1:0]  head_m   [SETS];
    logic [19:0] colcnt_m [SETS];
    logic [4:0]  fills_m  [SETS];

    t_victim victim_q[$];
    int      errors;
    int      cycles;
    bit      idle_en;
    bit      hold_rsp;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic logic [4:0] col(logic [19:0] w, int c);
        return w[c*5 +: 5];
    endfunction

    function automatic void predict_request(logic [1:0] rt, logic [5:0] s, logic [3:0] w);
        int idx;
        int h;
        int best;
        bit any;
        logic [4:0] cm;
        idx = s * WAYS + w;
        case (rt)
            shc_pkg::REQ_HIT: begin
                if (fills_m[s] >= MAIN_WAYS) begin
                    for (int c = 0; c < shc_pkg::NUM_COLS; c++) begin
                        if (unseen_m[idx][c]) begin
                            cm = col(colcnt_m[s], c);
                            unseen_m[idx][c] = 1'b0;
                            order_m[idx][c*5 +: 5] = cm;
                            if (cm < shc_pkg::COL_MAX) cm++;
                            colcnt_m[s][c*5 +: 5] = cm;
                        end
                    end
                end
            end
            shc_pkg::REQ_FILL: begin
                if (fills_m[s] < MAIN_WAYS) begin
                    cls_m[idx] = 3'd0;
                end else begin
                    h = head_m[s];
                    cls_m[idx] = 3'(h + 1);
                    colcnt_m[s][h*5 +: 5] = '0;
                    head_m[s] = 2'(h + 1);
                end
                unseen_m[idx] = 4'hf;
                if (fills_m[s] < CAP) fills_m[s]++;
            end
            shc_pkg::REQ_VICTIM: begin
                h = head_m[s];
                any = 0;
                best = 0;
                for (int k = 0; k < WAYS; k++) begin
                    if (cls_m[s*WAYS+k] == 0 || cls_m[s*WAYS+k] == h + 1) begin
                        if (!any) begin
                            any = 1;
                            best = k;
                        end
                        if (unseen_m[s*WAYS+k][h]) begin
                            best = k;
                            break;
                        end
                        if (col(order_m[s*WAYS+k], h) > col(order_m[s*WAYS+best], h))
                            best = k;
                    end
                end
                if (!any) begin
                    victim_q.push_back('{way: 4'd0, from_main: 1'b0});
                end else begin
                    victim_q.push_back('{way: 4'(best),
                                         from_main: cls_m[s*WAYS+best] == 0});
                    for (int k = 0; k < WAYS; k++)
                        if (cls_m[s*WAYS+k] == 0 || cls_m[s*WAYS+k] == h + 1)
                            unseen_m[s*WAYS+k][h] = 1'b1;
                    if (cls_m[s*WAYS+best] == 0)
                        for (int k = 0; k < WAYS; k++)
                            if (cls_m[s*WAYS+k] == h + 1) cls_m[s*WAYS+k] = 3'd0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(logic [1:0] rt, logic [5:0] s, logic [3:0] w);
        while (idle_en && $urandom_range(99) < 26) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.set_index <= s;
        req_ch.way_index <= w;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(rt, s, w);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (victim_q.size() != 0) @(negedge i_clk);
        repeat (2 * WAYS + 8) @(negedge i_clk);
    endtask

    // warm a set: fill every way
    task automatic warm_set(logic [5:0] s);
        for (int k = 0; k < WAYS; k++) send_request(shc_pkg::REQ_FILL, s, 4'(k));
    endtask

    task automatic test_directed();
        send_request(shc_pkg::REQ_VICTIM, 6'd0, 4'd0);
        send_request(shc_pkg::REQ_HIT, 6'd63, 4'd15);
        send_request(shc_pkg::REQ_NONE, 6'd63, 4'd15);
        warm_set(6'd63);
        send_request(shc_pkg::REQ_HIT, 6'd63, 4'd15);
        send_request(shc_pkg::REQ_HIT, 6'd63, 4'd0);
        send_request(shc_pkg::REQ_VICTIM, 6'd63, 4'd15);
        send_request(shc_pkg::REQ_VICTIM, 6'd63, 4'd0);
    endtask

    // hammer one set with hits to drive up its column counters, then query
    task automatic test_saturation();
        warm_set(6'd5);
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < WAYS; k++) send_request(shc_pkg::REQ_HIT, 6'd5, 4'(k));
        for (int k = 0; k < 6; k++) send_request(shc_pkg::REQ_VICTIM, 6'd5, 4'(k));
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [5:0] s;
        int r;
        for (int i = 0; i < n; i++) begin
            idle_en = !(i >= n/3 && i < n/3 + 80);
            s = (i % 5 == 4) ? 6'($urandom) : 6'($urandom_range(7));
            r = $urandom_range(99);
            if (r < 45)      send_request(shc_pkg::REQ_HIT, s, 4'($urandom));
            else if (r < 75) send_request(shc_pkg::REQ_FILL, s, 4'($urandom));
            else if (r < 97) send_request(shc_pkg::REQ_VICTIM, s, 4'($urandom));
            else             send_request(shc_pkg::REQ_NONE, s, 4'($urandom));
        end
        idle_en = 1;
    endtask

    task automatic test_backpressure();
        hold_rsp = 1;
        for (int i = 0; i < 20; i++)
            send_request(i % 2 ? shc_pkg::REQ_VICTIM : shc_pkg::REQ_HIT,
                         6'($urandom_range(7)), 4'($urandom));
        wait_drained();
    endtask

    // sink: random stall, or a long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_rsp = 0;
            end else begin
                rsp_ch.ready <= !(idle_en && $urandom_range(99) < 26);
            end
        end
    end

    always @(posedge i_clk) begin
        t_victim exp_v;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (victim_q.size() == 0) begin
                $display("%0t unexpected victim way=%0d main=%0b", $time,
                         rsp_ch.victim_way, rsp_ch.victim_from_main);
                errors++;
            end else begin
                exp_v = victim_q.pop_front();
                if (rsp_ch.victim_way !== exp_v.way) begin
                    $display("%0t victim_way expected %0d actual %0d", $time,
                             exp_v.way, rsp_ch.victim_way);
                    errors++;
                end
                if (rsp_ch.victim_from_main !== exp_v.from_main) begin
                    $display("%0t victim_from_main expected %0b actual %0b", $time,
                             exp_v.from_main, rsp_ch.victim_from_main);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        errors   = 0;
        cycles   = 0;
        idle_en  = 1;
        hold_rsp = 0;
        i_rst_n  = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = shc_pkg::REQ_HIT;
        req_ch.set_index = '0;
        req_ch.way_index = '0;
        for (int i = 0; i < SETS*WAYS; i++) begin
            cls_m[i] = '0; unseen_m[i] = 4'hf; order_m[i] = '0;
        end
        for (int i = 0; i < SETS; i++) begin
            head_m[i] = '0; colcnt_m[i] = '0; fills_m[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_backpressure();
        test_random(620);
        wait_drained();
        if (errors == 0 && victim_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
